// ===== rtl/core/llab_pkg.sv =====
// Shared constants for the leader clustering labeler.
package llab_pkg;

  localparam int NUM_GENES = 9;
  localparam int LABEL_W   = 7;
  localparam int THR_W     = 40;
  localparam int DIST_MAX_W = 64;

  localparam logic [THR_W-1:0] THR_RESET = 40'd65536;

endpackage

// ===== rtl/core/llab_ifs.sv =====
// Valid/ready channel interfaces: genome words in, label words out, threshold writes.
interface llab_in_if #(
  parameter int GENE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic                        first_of_pass;
  logic signed [GENE_BITS-1:0] gene_0;
  logic signed [GENE_BITS-1:0] gene_1;
  logic signed [GENE_BITS-1:0] gene_2;
  logic signed [GENE_BITS-1:0] gene_3;
  logic signed [GENE_BITS-1:0] gene_4;
  logic signed [GENE_BITS-1:0] gene_5;
  logic signed [GENE_BITS-1:0] gene_6;
  logic signed [GENE_BITS-1:0] gene_7;
  logic signed [GENE_BITS-1:0] gene_8;

  modport source (
    output valid, first_of_pass, gene_0, gene_1, gene_2, gene_3, gene_4,
           gene_5, gene_6, gene_7, gene_8,
    input  ready
  );
  modport sink (
    input  valid, first_of_pass, gene_0, gene_1, gene_2, gene_3, gene_4,
           gene_5, gene_6, gene_7, gene_8,
    output ready
  );
endinterface

interface llab_out_if;
  logic                          valid;
  logic                          ready;
  logic [llab_pkg::LABEL_W-1:0]  species_label;
  logic                          new_species;
  logic                          table_overflow;

  modport source (
    output valid, species_label, new_species, table_overflow,
    input  ready
  );
  modport sink (
    input  valid, species_label, new_species, table_overflow,
    output ready
  );
endinterface

interface llab_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [llab_pkg::THR_W-1:0]  sq_limit;

  modport source (output valid, sq_limit, input ready);
  modport sink (input valid, sq_limit, output ready);
endinterface

// ===== rtl/core/leader_clustering_labeler.sv =====
// Leader clustering labeler: nearest-representative search over a genome table.
//
// Channels: genome (sink) carries one 9-gene signed word plus first_of_pass;
// label (source) returns one word per genome: species_label, new_species,
// table_overflow. cfg (sink) writes sq_limit and is always ready; the user must
// see that it is written only while the block is idle, which is not enforced.
//
// Each genome is compared against every stored representative, one per cycle,
// read from a single RAM row holding all nine genes, through a five-stage pipe
// (read, abs diff, square, partial sums, total) into a running minimum. The
// scan reads one row per stored representative, N of them, at most MAX_REPS;
// the label word turns valid as the block is ready for the next genome.
// first_of_pass zeroes the representative count before the scan.
//
// A new representative is written into the RAM at the end of its item, so reads
// never overlap a pending write. The result lands in an output register and the
// next genome is accepted while it waits; if the receiver stalls, the finished
// result holds in the decision state until the register frees up. Reset clears
// the count and the control state and loads the limit 65536.
module leader_clustering_labeler #(
  parameter int MAX_REPS  = 64,
  parameter int GENE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  llab_in_if.sink    genome,
  llab_out_if.source label,
  llab_cfg_if.sink   cfg
);

  import llab_pkg::*;

  localparam int G       = GENE_BITS;
  localparam int IDX_W   = (MAX_REPS > 1) ? $clog2(MAX_REPS) : 1;
  localparam int CNT_W   = $clog2(MAX_REPS + 1);
  localparam int ROW_W   = NUM_GENES * G;
  localparam int SQ_W    = 2 * G;
  localparam int PS_W    = SQ_W + 2;
  localparam int SUM_W   = SQ_W + 4;
  localparam int DIST_W  = (SUM_W > DIST_MAX_W) ? DIST_MAX_W : SUM_W;
  localparam int CMP_W   = (DIST_W > THR_W) ? DIST_W : THR_W;
  localparam int EXT_W   = (CNT_W > LABEL_W) ? CNT_W : LABEL_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state;
  logic [THR_W-1:0]  threshold;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  iss_idx;
  logic [ROW_W-1:0]  gene_row;
  logic [ROW_W-1:0]  rdata;

  // distance pipe
  logic              v_rd, v_abs, v_sq, v_ps, v_dist;
  logic [IDX_W-1:0]  idx_rd, idx_abs, idx_sq, idx_ps, idx_dist;
  logic [G-1:0]      absd [NUM_GENES];
  logic [SQ_W-1:0]   sq   [NUM_GENES];
  logic [PS_W-1:0]   ps   [3];
  logic [DIST_W-1:0] gap_sq;
  logic [DIST_W-1:0] gap_sq_next;
  logic [SUM_W-1:0]  total;

  // running minimum
  logic              found;
  logic [DIST_W-1:0] best;
  logic [IDX_W-1:0]  near_idx;

  // output register
  logic               out_valid;
  logic [LABEL_W-1:0] out_label;
  logic               out_new;
  logic               out_ovf;

  logic               issue;
  logic               pipe_busy;
  logic               slot_free;
  logic               done_load;
  logic               is_match;
  logic               has_room;
  logic [CNT_W-1:0]   lbl_cnt;
  logic [EXT_W-1:0]   lbl_ext;
  logic [ROW_W-1:0]   in_row;

  function automatic logic [G-1:0] abs_diff(input logic [G-1:0] a, input logic [G-1:0] b);
    logic signed [G:0] diff;
    logic signed [G:0] negd;
    diff = $signed({a[G-1], a}) - $signed({b[G-1], b});
    negd = -diff;
    return diff[G] ? negd[G-1:0] : diff[G-1:0];
  endfunction

  assign genome.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  assign label.valid          = out_valid;
  assign label.species_label  = out_label;
  assign label.new_species    = out_new;
  assign label.table_overflow = out_ovf;

  assign in_row = {genome.gene_8, genome.gene_7, genome.gene_6, genome.gene_5,
                   genome.gene_4, genome.gene_3, genome.gene_2, genome.gene_1,
                   genome.gene_0};

  assign issue     = (state == S_SCAN) && (iss_idx != count);
  assign pipe_busy = v_rd || v_abs || v_sq || v_ps || v_dist;
  assign slot_free = !out_valid || label.ready;
  assign done_load = (state == S_DONE) && slot_free;

  assign is_match = found && (CMP_W'(best) < CMP_W'(threshold));
  assign has_room = (count < CNT_W'(MAX_REPS));

  // Label is index plus one; a new entry gets the count after the increment.
  always_comb begin
    if (!is_match && has_room) begin
      lbl_cnt = count + CNT_W'(1);
    end else begin
      lbl_cnt = CNT_W'(near_idx) + CNT_W'(1);
    end
    lbl_ext = EXT_W'(lbl_cnt);
  end

  llab_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_REPS)
  ) u_rep_ram (
    .clk   (clk),
    .we    (done_load && !is_match && has_room),
    .waddr (count[IDX_W-1:0]),
    .wdata (gene_row),
    .re    (issue),
    .raddr (iss_idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Clamp the nine-square sum to the distance width.
  assign total = SUM_W'(ps[0]) + SUM_W'(ps[1]) + SUM_W'(ps[2]);
  generate
    if (SUM_W > DIST_W) begin : g_sat
      assign gap_sq_next = (|total[SUM_W-1:DIST_W]) ? {DIST_W{1'b1}} : total[DIST_W-1:0];
    end else begin : g_nosat
      assign gap_sq_next = total;
    end
  endgenerate

  // Datapath stages: no reset needed on payload.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_GENES; k++) begin
      absd[k] <= abs_diff(gene_row[k*G +: G], rdata[k*G +: G]);
      sq[k]   <= SQ_W'(absd[k]) * SQ_W'(absd[k]);
    end
    for (int j = 0; j < 3; j++) begin
      ps[j] <= PS_W'(sq[3*j]) + PS_W'(sq[3*j+1]) + PS_W'(sq[3*j+2]);
    end
    gap_sq   <= gap_sq_next;
    idx_rd   <= iss_idx[IDX_W-1:0];
    idx_abs  <= idx_rd;
    idx_sq   <= idx_abs;
    idx_ps   <= idx_sq;
    idx_dist <= idx_ps;
    if (genome.valid && genome.ready) begin
      gene_row <= in_row;
    end
  end

  // Control: scan sequencer, running minimum, count, output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      threshold <= THR_RESET;
      count     <= '0;
      iss_idx   <= '0;
      v_rd      <= 1'b0;
      v_abs     <= 1'b0;
      v_sq      <= 1'b0;
      v_ps      <= 1'b0;
      v_dist    <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        threshold <= cfg.sq_limit;
      end

      v_rd   <= issue;
      v_abs  <= v_rd;
      v_sq   <= v_abs;
      v_ps   <= v_sq;
      v_dist <= v_ps;

      if (v_dist && (!found || gap_sq < best)) begin
        found    <= 1'b1;
        best     <= gap_sq;
        near_idx <= idx_dist;
      end

      // Drop the word once taken, unless a new one loads in the same cycle.
      if (out_valid && label.ready && !done_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (genome.valid) begin
            if (genome.first_of_pass) begin
              count <= '0;
            end
            iss_idx <= '0;
            found   <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            iss_idx <= iss_idx + CNT_W'(1);
          end else if (!pipe_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_label <= lbl_ext[LABEL_W-1:0];
            out_new   <= !is_match && has_room;
            out_ovf   <= !is_match && !has_room;
            if (!is_match && has_room) begin
              count <= count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Reads only touch rows that have been written in this pass.
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (iss_idx < count))
    else $error("representative read beyond count");

  // A new representative bumps the count by exactly one.
  a_new_bumps_count: assert property (@(posedge clk) disable iff (rst)
    (done_load && !is_match && has_room) |=> (count == $past(count) + CNT_W'(1)))
    else $error("count did not advance on new representative");

  // A genome is taken only with the distance pipe drained.
  a_accept_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (genome.valid && genome.ready) |-> !pipe_busy)
    else $error("genome accepted while pipe busy");

  // A result is never both a new entry and an overflow.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_new && out_ovf))
    else $error("new_species and table_overflow both set");

  // The count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done_load |=> (count <= CNT_W'(MAX_REPS)))
    else $error("representative count overflow");

endmodule

// ===== rtl/core/llab_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module llab_ram #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
